// ===== design/fw2d_pkg.sv =====
// ----------------------------------------------------------------------------
// fw2d_pkg
// Shared widths, the work item carried from front to back, and a helper for
// the two-dimensional Fenwick rectangle-sum block.
// ----------------------------------------------------------------------------
package fw2d_pkg;

  // field widths fixed by the item format
  localparam int unsigned POS_W = 10;
  localparam int unsigned CRD_W = POS_W + 1;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned SUM_W = 52;

  // classified work item, query corners already clamped and one-based on the far side
  typedef struct packed {
    logic             is_query;
    logic [POS_W-1:0] pos_row;
    logic [POS_W-1:0] pos_col;
    logic [VAL_W-1:0] value;
    logic [CRD_W-1:0] top_row;
    logic [CRD_W-1:0] left_col;
    logic [CRD_W-1:0] bot_row;
    logic [CRD_W-1:0] rgt_col;
  } item_t;

  // sign-extend a cell value to the sum width
  function automatic logic [SUM_W-1:0] sext_val(input logic [VAL_W-1:0] v);
    return {{(SUM_W - VAL_W){v[VAL_W-1]}}, v};
  endfunction

endpackage

// ===== design/fw2d_fifo.sv =====
// ----------------------------------------------------------------------------
// fw2d_fifo
// Small synchronous queue; drops a push when full and a pop when empty.
// ----------------------------------------------------------------------------
module fw2d_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned NW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_P = PW'(DEPTH - 1);
  localparam logic [NW-1:0] FULL_N = NW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [NW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FULL_N);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_q];

  // pointer and fill count update
  always_comb begin
    wr_d  = do_push ? ((wr_q == LAST_P) ? '0 : wr_q + PW'(1)) : wr_q;
    rd_d  = do_pop ? ((rd_q == LAST_P) ? '0 : rd_q + PW'(1)) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + NW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== design/fw2d_front.sv =====
// ----------------------------------------------------------------------------
// fw2d_front
// Accepts input beats, clamps query corners, drops sets outside the matrix
// and hands the classified item to the work queue.
// ----------------------------------------------------------------------------
module fw2d_front
  import fw2d_pkg::*;
#(
  parameter int unsigned SIDE = 1024
) (
  input  logic             push,
  output logic             full,
  input  logic             func_i,
  input  logic [POS_W-1:0] pos_row_i,
  input  logic [POS_W-1:0] pos_col_i,
  input  logic [VAL_W-1:0] value_i,
  input  logic [POS_W-1:0] top_row_i,
  input  logic [POS_W-1:0] left_col_i,
  input  logic [POS_W-1:0] bottom_row_i,
  input  logic [POS_W-1:0] right_col_i,
  input  logic             busy_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output item_t            q_item_o
);

  localparam logic [12:0] MAX_C  = 13'(SIDE - 1);
  localparam logic [12:0] SIDE_C = 13'(SIDE);

  function automatic logic [POS_W-1:0] clamp(input logic [POS_W-1:0] x);
    if ({3'b000, x} > MAX_C) begin
      return MAX_C[POS_W-1:0];
    end
    return x;
  endfunction

  logic accept, in_range;

  assign full     = q_full_i | busy_i;
  assign accept   = push & ~full;
  assign in_range = ({3'b000, pos_row_i} < SIDE_C) && ({3'b000, pos_col_i} < SIDE_C);

  // sets outside the matrix never reach the back end
  assign q_push_o = accept & (func_i | in_range);

  // classify and normalize the beat
  always_comb begin
    q_item_o.is_query = func_i;
    q_item_o.pos_row  = pos_row_i;
    q_item_o.pos_col  = pos_col_i;
    q_item_o.value    = value_i;
    q_item_o.top_row  = {1'b0, clamp(top_row_i)};
    q_item_o.left_col = {1'b0, clamp(left_col_i)};
    q_item_o.bot_row  = {1'b0, clamp(bottom_row_i)} + CRD_W'(1);
    q_item_o.rgt_col  = {1'b0, clamp(right_col_i)} + CRD_W'(1);
  end

endmodule

// ===== design/fw2d_back.sv =====
// ----------------------------------------------------------------------------
// fw2d_back
// Executes items: clears both stores after reset, walks the Fenwick update
// paths for a set, and the four prefix paths for a query.
// ----------------------------------------------------------------------------
module fw2d_back
  import fw2d_pkg::*;
#(
  parameter int unsigned SIDE = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  input  item_t            item_i,
  output logic             item_pop_o,
  input  logic             res_full_i,
  output logic             res_push_o,
  output logic [SUM_W-1:0] res_data_o,
  output logic             busy_o
);

  localparam int unsigned CW = $clog2(SIDE + 1);
  localparam int unsigned WW = CW + 1;
  localparam int unsigned AW = $clog2(SIDE * SIDE);
  localparam logic [WW-1:0] SIDE_W = WW'(SIDE);
  localparam logic [AW-1:0] SIDE_A = AW'(SIDE);
  localparam logic [AW-1:0] LAST_A = AW'(SIDE * SIDE - 1);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_VRD   = 8'b0000_0100,
    S_DELTA = 8'b0000_1000,
    S_URD   = 8'b0001_0000,
    S_UWR   = 8'b0010_0000,
    S_QWALK = 8'b0100_0000,
    S_QOUT  = 8'b1000_0000
  } state_e;

  // flat address of a one-based cell
  function automatic logic [AW-1:0] cell_addr(input logic [WW-1:0] r1,
                                              input logic [WW-1:0] k1);
    logic [WW-1:0] r0, k0;
    r0 = r1 - WW'(1);
    k0 = k1 - WW'(1);
    return AW'(r0) * SIDE_A + AW'(k0);
  endfunction

  function automatic logic [WW-1:0] low_bit(input logic [WW-1:0] x);
    return x & (~x + WW'(1));
  endfunction

  // corner order: (b,r,+) (t,r,-) (b,l,-) (t,l,+)
  function automatic logic [WW-1:0] corner_row(input item_t it, input logic [1:0] q);
    return q[0] ? WW'(it.top_row) : WW'(it.bot_row);
  endfunction

  function automatic logic [WW-1:0] corner_col(input item_t it, input logic [1:0] q);
    return q[1] ? WW'(it.left_col) : WW'(it.rgt_col);
  endfunction

  state_e           state_q, state_d;
  item_t            cur_q, cur_d;
  logic [WW-1:0]    r_q, r_d, k_q, k_d;
  logic [1:0]       q_q, q_d;
  logic [SUM_W-1:0] acc_q, acc_d, delta_q, delta_d, delta_c;
  logic [AW-1:0]    addr_q, addr_d, clr_q, clr_d;
  logic             rdv_q, rdv_d, neg_q, neg_d;
  logic [WW-1:0]    k_next, r_next;

  // store ports
  logic [SUM_W-1:0] fen_mem [SIDE * SIDE];
  logic [VAL_W-1:0] val_mem [SIDE * SIDE];
  logic [SUM_W-1:0] fen_rdata_q, fen_wdata;
  logic [VAL_W-1:0] val_rdata_q, val_wdata;
  logic [AW-1:0]    fen_raddr, fen_waddr, val_raddr, val_waddr;
  logic             fen_re, fen_we, val_re, val_we;

  assign busy_o     = (state_q == S_CLEAR);
  assign res_data_o = acc_q;
  assign delta_c    = sext_val(cur_q.value) - sext_val(val_rdata_q);

  // sequencer
  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    r_d        = r_q;
    k_d        = k_q;
    q_d        = q_q;
    acc_d      = acc_q;
    delta_d    = delta_q;
    addr_d     = addr_q;
    clr_d      = clr_q;
    rdv_d      = 1'b0;
    neg_d      = neg_q;
    item_pop_o = 1'b0;
    res_push_o = 1'b0;
    fen_re     = 1'b0;
    fen_we     = 1'b0;
    val_re     = 1'b0;
    val_we     = 1'b0;
    fen_raddr  = cell_addr(r_q, k_q);
    fen_waddr  = addr_q;
    fen_wdata  = fen_rdata_q + delta_q;
    val_raddr  = cell_addr(WW'(cur_q.pos_row) + WW'(1), WW'(cur_q.pos_col) + WW'(1));
    val_waddr  = addr_q;
    val_wdata  = cur_q.value;
    k_next     = k_q;
    r_next     = r_q;

    // fold in the prefix read issued last cycle
    if (rdv_q) begin
      acc_d = neg_q ? (acc_q - fen_rdata_q) : (acc_q + fen_rdata_q);
    end

    case (state_q)
      S_CLEAR: begin
        fen_we    = 1'b1;
        val_we    = 1'b1;
        fen_waddr = clr_q;
        val_waddr = clr_q;
        fen_wdata = '0;
        val_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == LAST_A) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          cur_d      = item_i;
          if (item_i.is_query) begin
            q_d     = 2'd0;
            r_d     = corner_row(item_i, 2'd0);
            k_d     = corner_col(item_i, 2'd0);
            acc_d   = '0;
            state_d = S_QWALK;
          end else begin
            state_d = S_VRD;
          end
        end
      end
      S_VRD: begin
        val_re  = 1'b1;
        addr_d  = val_raddr;
        state_d = S_DELTA;
      end
      S_DELTA: begin
        val_we  = 1'b1;
        delta_d = delta_c;
        r_d     = WW'(cur_q.pos_row) + WW'(1);
        k_d     = WW'(cur_q.pos_col) + WW'(1);
        state_d = (delta_c == '0) ? S_IDLE : S_URD;
      end
      S_URD: begin
        fen_re  = 1'b1;
        addr_d  = fen_raddr;
        state_d = S_UWR;
      end
      S_UWR: begin
        fen_we = 1'b1;
        k_next = k_q + low_bit(k_q);
        r_next = r_q + low_bit(r_q);
        if (k_next <= SIDE_W) begin
          k_d     = k_next;
          state_d = S_URD;
        end else if (r_next <= SIDE_W) begin
          r_d     = r_next;
          k_d     = WW'(cur_q.pos_col) + WW'(1);
          state_d = S_URD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_QWALK: begin
        if (r_q == '0 || k_q == '0) begin
          // this corner is exhausted
          if (q_q == 2'd3) begin
            state_d = S_QOUT;
          end else begin
            q_d = q_q + 2'd1;
            r_d = corner_row(cur_q, q_q + 2'd1);
            k_d = corner_col(cur_q, q_q + 2'd1);
          end
        end else begin
          fen_re = 1'b1;
          rdv_d  = 1'b1;
          neg_d  = q_q[0] ^ q_q[1];
          k_next = k_q - low_bit(k_q);
          if (k_next == '0) begin
            r_d = r_q - low_bit(r_q);
            k_d = corner_col(cur_q, q_q);
          end else begin
            k_d = k_next;
          end
        end
      end
      S_QOUT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      rdv_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      rdv_q   <= rdv_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    r_q     <= r_d;
    k_q     <= k_d;
    q_q     <= q_d;
    acc_q   <= acc_d;
    delta_q <= delta_d;
    addr_q  <= addr_d;
    neg_q   <= neg_d;
  end

  // fenwick store
  always_ff @(posedge clk_i) begin
    if (fen_we) begin
      fen_mem[fen_waddr] <= fen_wdata;
    end
    if (fen_re) begin
      fen_rdata_q <= fen_mem[fen_raddr];
    end
  end

  // cell value store
  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[val_waddr] <= val_wdata;
    end
    if (val_re) begin
      val_rdata_q <= val_mem[val_raddr];
    end
  end

  // update walk stays inside the matrix
  a_upd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_URD) |-> (r_q != '0 && k_q != '0 && r_q <= SIDE_W && k_q <= SIDE_W))
    else $error("update walk left the matrix");

  // a result is only formed after the last corner
  a_out_last_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_QOUT) |-> (q_q == 2'd3 && !rdv_q))
    else $error("result formed before all corners were summed");

  // no result pushed into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed while queue full");

  // no item taken from an empty queue or during clearing
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop_o |-> (item_valid_i && !busy_o))
    else $error("item taken without one waiting");

  // a prefix read is only pending right after a walk step
  a_rdv_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdv_q |-> $past(state_q == S_QWALK))
    else $error("stray prefix read");

endmodule

// ===== design/fenwick_2d_rect_sum_top.sv =====
// ----------------------------------------------------------------------------
// fenwick_2d_rect_sum_top
// Two-dimensional Fenwick tree over a SIDE x SIDE matrix: set one cell or
// return an inclusive rectangle sum.
//
//   channel  direction  handshake            beat
//   input    in         push / full          func, set cell, query corners
//   result   out        empty / pop          rect_sum (queries only)
//
// A query is taken, reads one Fenwick cell at a time on its four prefix paths
// through the single fenwick read port, and then delivers its sum. A set reads
// the old cell value and, if the value changes, walks its update path with one
// read-modify-write per cell through one port.
// After reset both stores are cleared, one entry a cycle, with full held high.
// A work queue of two items and a result queue of two items sit between the
// back end and either side.
// ----------------------------------------------------------------------------
module fenwick_2d_rect_sum_top
  import fw2d_pkg::*;
#(
  parameter int unsigned SIDE = 1024
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic                    func_i,
  input  logic [POS_W-1:0]        pos_row_i,
  input  logic [POS_W-1:0]        pos_col_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic [POS_W-1:0]        top_row_i,
  input  logic [POS_W-1:0]        left_col_i,
  input  logic [POS_W-1:0]        bottom_row_i,
  input  logic [POS_W-1:0]        right_col_i,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [SUM_W-1:0] rect_sum_o
);

  logic             busy, wq_push, wq_full, wq_empty, wq_pop;
  item_t            wq_in, wq_out;
  logic             rq_push, rq_full;
  logic [SUM_W-1:0] rq_in, rq_out;

  // front: accept and classify
  fw2d_front #(.SIDE(SIDE)) u_front (
    .push         (push),
    .full         (full),
    .func_i       (func_i),
    .pos_row_i    (pos_row_i),
    .pos_col_i    (pos_col_i),
    .value_i      (VAL_W'(value_i)),
    .top_row_i    (top_row_i),
    .left_col_i   (left_col_i),
    .bottom_row_i (bottom_row_i),
    .right_col_i  (right_col_i),
    .busy_i       (busy),
    .q_full_i     (wq_full),
    .q_push_o     (wq_push),
    .q_item_o     (wq_in)
  );

  // work queue between front and back
  fw2d_fifo #(.WIDTH($bits(item_t)), .DEPTH(2)) u_work_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (wq_push),
    .data_i  (wq_in),
    .full_o  (wq_full),
    .pop_i   (wq_pop),
    .data_o  (wq_out),
    .empty_o (wq_empty)
  );

  // back: execute against the stores
  fw2d_back #(.SIDE(SIDE)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (~wq_empty),
    .item_i       (wq_out),
    .item_pop_o   (wq_pop),
    .res_full_i   (rq_full),
    .res_push_o   (rq_push),
    .res_data_o   (rq_in),
    .busy_o       (busy)
  );

  // result queue toward the consumer
  fw2d_fifo #(.WIDTH(SUM_W), .DEPTH(2)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rq_push),
    .data_i  (rq_in),
    .full_o  (rq_full),
    .pop_i   (pop),
    .data_o  (rq_out),
    .empty_o (empty)
  );

  assign rect_sum_o = signed'(rq_out);

endmodule
